// ===== rtl/shsad_pkg.sv =====
// Shared types and constants for the shifted SAD template matcher.
// No dependencies; imported by the top level and the divider.
package shsad_pkg;

   localparam int CELL_W = 16;

   // Mean tolerance added to the threshold in the prefilter (0.005 in Q0.16).
   localparam logic [16:0] MEAN_EPSILON = 17'd328;
   localparam logic [15:0] ERR_SATURATE = 16'hFFFF;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT_RANGE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT_STEP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PANORAMIC   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_COLUMNS     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ROWS        = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_SCAN_INIT,
      ST_MEAN_RD,
      ST_MEAN_CHK,
      ST_RUN,
      ST_DRAIN,
      ST_CMP,
      ST_RESOLVE,
      ST_ERR_GO,
      ST_ERR_WAIT,
      ST_DECIDE,
      ST_COPY,
      ST_OUT
   } state_type;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

// ===== rtl/shsad_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on shsad_pkg for the control struct.
module shsad_div import shsad_pkg::*; #(
   parameter int DW = 26,
   parameter int VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output div_ctl_type   status
);

   localparam int CNTW = $clog2(DW + 1);

   logic [VW-1:0]   rem_ff;
   logic [DW-1:0]   quo_ff;
   logic [VW-1:0]   div_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [VW:0]     shifted;
   logic            fits;
   logic [VW:0]     diff;
   logic [VW-1:0]   rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      fits    = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};
      rem_in  = fits ? diff[VW-1:0] : shifted[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign quotient     = quo_ff;
   assign status.done  = done_ff;
   assign status.start = start;

endmodule

// ===== rtl/shifted_sad_template_match.sv =====
// Top level of the shifted SAD template matcher: view buffer, template store,
// scan sequencer and result register. Depends on shsad_pkg and shsad_div.
//
//  channel  | direction | payload
//  req_     | in        | tdata[15:0] = cell_value
//  rsp_     | out       | tdata[39:0] = matched, template_id, match_error,
//           |           |   no_candidate, column_shift, store_full, zero pad
//  csr_     | in        | write enable, register index, 16-bit data
//
// Cells are taken one per cycle. When a view completes, the block leaves ready low while
// the sequencer runs: the divider forms the mean, then each stored template gets a mean check
// and, if that passes, for each tried offset a pass of R*W cells through the single SAD
// unit (W = compared columns); then the divider forms the error if a candidate was found, and
// a new template is copied to the store when there is no match and the store has room.
// Reset is synchronous and clears the counts; memories are not cleared.
// A waiting result holds the sequencer in its output state until taken.
module shifted_sad_template_match import shsad_pkg::*; #(
   parameter int MAX_COLUMNS   = 64,
   parameter int MAX_ROWS      = 16,
   parameter int MAX_TEMPLATES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] cell_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [0] matched, [8:1] template_id,
                                              // [24:9] match_error, [25] no_candidate,
                                              // [32:26] column_shift, [33] store_full
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wdata
);

   localparam int VIEW_CELLS  = MAX_COLUMNS * MAX_ROWS;
   localparam int CW          = $clog2(MAX_COLUMNS + 1);
   localparam int RW          = $clog2(MAX_ROWS + 1);
   localparam int NW          = $clog2(VIEW_CELLS + 1);
   localparam int VAW         = $clog2(VIEW_CELLS);
   localparam int SUMW        = CELL_W + NW;
   localparam int TW          = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
   localparam int SCW         = $clog2(MAX_TEMPLATES + 1);
   localparam int STORE_DEPTH = MAX_TEMPLATES * VIEW_CELLS;
   localparam int SAW         = $clog2(STORE_DEPTH);
   localparam int OW          = $clog2(MAX_COLUMNS + 64);

   // Configuration registers.
   logic [15:0] threshold_ff;
   logic [4:0]  shift_range_ff;
   logic [5:0]  shift_step_ff;
   logic        pano_ff;
   logic [6:0]  columns_ff;
   logic [4:0]  rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= 16'd1966;
         shift_range_ff <= 5'd25;
         shift_step_ff  <= 6'd5;
         pano_ff        <= 1'b0;
         columns_ff     <= 7'd64;
         rows_ff        <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_THRESHOLD:   threshold_ff   <= csr_wdata;
            REG_SHIFT_RANGE: shift_range_ff <= csr_wdata[4:0];
            REG_SHIFT_STEP:  shift_step_ff  <= csr_wdata[5:0];
            REG_PANORAMIC:   pano_ff        <= csr_wdata[0];
            REG_COLUMNS:     columns_ff     <= csr_wdata[6:0];
            REG_ROWS:        rows_ff        <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Derived geometry.
   logic [31:0]      col32, row32, sr32, s32;
   logic [CW-1:0]    col_c, half_c, s_val, s_eff, w_cells;
   logic [RW-1:0]    row_c;
   logic [CW+RW-1:0] n_prod, rw_prod;
   logic [NW-1:0]    n_cells, cells;
   logic [5:0]       step_eff;

   always_comb begin
      col32 = {25'd0, columns_ff};
      row32 = {27'd0, rows_ff};
      if (col32 == 32'd0)
         col32 = 32'd1;
      else if (col32 > MAX_COLUMNS)
         col32 = MAX_COLUMNS;
      if (row32 == 32'd0)
         row32 = 32'd1;
      else if (row32 > MAX_ROWS)
         row32 = MAX_ROWS;
      col_c   = col32[CW-1:0];
      row_c   = row32[RW-1:0];
      half_c  = (col_c - 1'b1) >> 1;
      sr32    = {27'd0, shift_range_ff};
      s32     = (sr32 < 32'(half_c)) ? sr32 : 32'(half_c);
      s_val   = s32[CW-1:0];
      s_eff   = pano_ff ? '0 : s_val;
      w_cells = col_c - (s_eff << 1);
      n_prod  = {{RW{1'b0}}, col_c} * {{CW{1'b0}}, row_c};
      rw_prod = {{RW{1'b0}}, w_cells} * {{CW{1'b0}}, row_c};
      n_cells = n_prod[NW-1:0];
      cells   = pano_ff ? n_cells : rw_prod[NW-1:0];
      step_eff = (shift_step_ff == 6'd0) ? 6'd1 : shift_step_ff;
   end

   // State.
   state_type state_ff, state_in;

   logic [NW-1:0]     cnt_ff;
   logic [SUMW-1:0]   sum_ff;
   logic [SCW-1:0]    stored_ff;
   logic [SAW-1:0]    store_base_ff;
   logic              rsp_valid_ff;
   logic              p1_ff;
   logic              cp_v_ff;

   logic [15:0]       mean_ff;
   logic [SCW-1:0]    t_ff;
   logic [SAW-1:0]    tbase_ff;
   logic [OW-1:0]     off_ff;
   logic [CW-1:0]     x_ff, vcol_ff, tc_ff;
   logic [RW-1:0]     r_ff;
   logic [VAW-1:0]    row_base_ff;
   logic [SUMW-1:0]   sad_ff, best_ff, prod_ff;
   logic              found_ff;
   logic [SCW-1:0]    best_id_ff;
   logic [OW-1:0]     best_off_ff;
   logic [NW-1:0]     cp_i_ff;
   logic [SAW-1:0]    cp_addr_ff;
   logic [SUMW-1:0]   div_a_ff;
   logic [NW-1:0]     div_b_ff;
   logic              res_matched_ff, res_full_ff;
   logic [7:0]        res_tid_ff;
   logic [15:0]       res_err_ff;
   logic [6:0]        res_shift_ff;
   logic              rsp_matched_ff, rsp_nc_ff, rsp_full_ff;
   logic [7:0]        rsp_tid_ff;
   logic [15:0]       rsp_err_ff;
   logic [6:0]        rsp_shift_ff;

   // Memories.
   logic [15:0] view_mem  [VIEW_CELLS];
   logic [15:0] store_mem [STORE_DEPTH];
   logic [15:0] mean_mem  [MAX_TEMPLATES];
   logic [15:0] vb_rd_ff, ts_rd_ff, mean_rd_ff;

   // Shared divider.
   logic [SUMW-1:0] quotient;
   div_ctl_type     div_ctl;
   logic            div_start;

   shsad_div #(.DW(SUMW), .VW(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .quotient (quotient),
      .status   (div_ctl)
   );

   // Sequencer conditions.
   logic            in_acc, view_done, last_col, last_issue, off_cont, more_tmpl;
   logic            skip, better, hit, out_free;
   logic [NW-1:0]   cnt_next;
   logic [OW-1:0]   off_nxt;
   logic [15:0]     mdiff;
   logic [16:0]     limit;
   logic [15:0]     adiff;
   logic [31:0]     vaddr32, taddr32, cpaddr32, off32, c32, sh32, tid32;
   logic [VAW-1:0]  vb_raddr, wr_idx;
   logic [SAW-1:0]  ts_raddr;

   always_comb begin
      in_acc    = req_tvalid && req_tready;
      cnt_next  = cnt_ff + 1'b1;
      view_done = cnt_next >= n_cells;
      last_col  = CW'(x_ff + 1'b1) == w_cells;
      last_issue = last_col && (RW'(r_ff + 1'b1) == row_c);
      off_nxt   = off_ff + OW'(step_eff);
      off_cont  = pano_ff ? (32'(off_nxt) < 32'(col_c))
                          : (32'(off_nxt) <= 32'(s_val) * 32'd2);
      more_tmpl = SCW'(t_ff + 1'b1) < stored_ff;
      mdiff     = (mean_ff > mean_rd_ff) ? mean_ff - mean_rd_ff : mean_rd_ff - mean_ff;
      limit     = {1'b0, threshold_ff} + MEAN_EPSILON;
      skip      = {1'b0, mdiff} > limit;
      better    = !found_ff || (sad_ff < best_ff);
      hit       = found_ff && (best_ff <= prod_ff);
      out_free  = !rsp_valid_ff || rsp_tready;
      adiff     = (vb_rd_ff > ts_rd_ff) ? vb_rd_ff - ts_rd_ff : ts_rd_ff - vb_rd_ff;
      vaddr32   = 32'(row_base_ff) + 32'(vcol_ff);
      taddr32   = 32'(tbase_ff) + 32'(row_base_ff) + 32'(tc_ff);
      cpaddr32  = 32'(store_base_ff) + 32'(cp_i_ff);
      vb_raddr  = (state_ff == ST_COPY) ? cp_i_ff[VAW-1:0] : vaddr32[VAW-1:0];
      ts_raddr  = taddr32[SAW-1:0];
      wr_idx    = (32'(cnt_ff) < VIEW_CELLS) ? cnt_ff[VAW-1:0] : VAW'(VIEW_CELLS - 1);
      off32     = 32'(best_off_ff);
      c32       = 32'(col_c);
      sh32      = (off32 * 32'd2 > c32) ? off32 - c32 : off32;
      tid32     = hit ? 32'(best_id_ff) : 32'(stored_ff);
   end

   // Next state and strobes.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (in_acc && view_done)
               state_in = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            div_start = 1'b1;
            state_in  = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_ctl.done)
               state_in = ST_SCAN_INIT;
         end
         ST_SCAN_INIT: begin
            state_in = (stored_ff == '0) ? ST_RESOLVE : ST_MEAN_RD;
         end
         ST_MEAN_RD: state_in = ST_MEAN_CHK;
         ST_MEAN_CHK: begin
            if (!skip)
               state_in = ST_RUN;
            else if (more_tmpl)
               state_in = ST_MEAN_RD;
            else
               state_in = ST_RESOLVE;
         end
         ST_RUN: begin
            if (last_issue)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_CMP;
         ST_CMP: begin
            if (off_cont)
               state_in = ST_RUN;
            else if (more_tmpl)
               state_in = ST_MEAN_RD;
            else
               state_in = ST_RESOLVE;
         end
         ST_RESOLVE: state_in = found_ff ? ST_ERR_GO : ST_DECIDE;
         ST_ERR_GO: begin
            div_start = 1'b1;
            state_in  = ST_ERR_WAIT;
         end
         ST_ERR_WAIT: begin
            if (div_ctl.done)
               state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!hit && (32'(stored_ff) < MAX_TEMPLATES))
               state_in = ST_COPY;
            else
               state_in = ST_OUT;
         end
         ST_COPY: begin
            if (NW'(cp_i_ff + 1'b1) == n_cells)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         sum_ff        <= '0;
         stored_ff     <= '0;
         store_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         p1_ff         <= 1'b0;
         cp_v_ff       <= 1'b0;
      end else begin
         p1_ff   <= (state_ff == ST_RUN);
         cp_v_ff <= (state_ff == ST_COPY);
         if (in_acc) begin
            if (view_done) begin
               cnt_ff <= '0;
               sum_ff <= '0;
            end else begin
               cnt_ff <= cnt_next;
               sum_ff <= sum_ff + {{NW{1'b0}}, req_tdata};
            end
         end
         if ((state_ff == ST_COPY) && (NW'(cp_i_ff + 1'b1) == n_cells)) begin
            stored_ff     <= stored_ff + 1'b1;
            store_base_ff <= SAW'(32'(store_base_ff) + VIEW_CELLS);
         end
         if ((state_ff == ST_OUT) && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            div_a_ff <= sum_ff + {{NW{1'b0}}, req_tdata};
            div_b_ff <= n_cells;
         end
         ST_MEAN_WAIT: begin
            if (div_ctl.done)
               mean_ff <= quotient[15:0];
         end
         ST_SCAN_INIT: begin
            found_ff <= 1'b0;
            t_ff     <= '0;
            tbase_ff <= '0;
            prod_ff  <= {{NW{1'b0}}, threshold_ff} * {{CELL_W{1'b0}}, cells};
         end
         ST_MEAN_CHK, ST_CMP: begin
            if ((state_ff == ST_CMP) && better) begin
               found_ff    <= 1'b1;
               best_ff     <= sad_ff;
               best_id_ff  <= t_ff;
               best_off_ff <= off_ff;
            end
            x_ff        <= '0;
            r_ff        <= '0;
            row_base_ff <= '0;
            vcol_ff     <= s_eff;
            sad_ff      <= '0;
            if (state_ff == ST_MEAN_CHK) begin
               off_ff <= '0;
               tc_ff  <= '0;
            end else begin
               off_ff <= off_nxt;
               tc_ff  <= off_nxt[CW-1:0];
            end
            if ((state_ff == ST_MEAN_CHK ? skip : !off_cont) && more_tmpl) begin
               t_ff     <= t_ff + 1'b1;
               tbase_ff <= SAW'(32'(tbase_ff) + VIEW_CELLS);
            end
         end
         ST_RUN: begin
            if (last_col) begin
               x_ff        <= '0;
               r_ff        <= r_ff + 1'b1;
               row_base_ff <= VAW'(32'(row_base_ff) + 32'(col_c));
               vcol_ff     <= s_eff;
               tc_ff       <= off_ff[CW-1:0];
            end else begin
               x_ff    <= x_ff + 1'b1;
               vcol_ff <= vcol_ff + 1'b1;
               tc_ff   <= (CW'(tc_ff + 1'b1) == col_c) ? '0 : tc_ff + 1'b1;
            end
         end
         ST_RESOLVE: begin
            div_a_ff   <= best_ff;
            div_b_ff   <= cells;
            res_err_ff <= ERR_SATURATE;
         end
         ST_ERR_WAIT: begin
            if (div_ctl.done)
               res_err_ff <= (quotient > SUMW'(ERR_SATURATE)) ? ERR_SATURATE
                                                                : quotient[15:0];
         end
         ST_DECIDE: begin
            cp_i_ff        <= '0;
            res_matched_ff <= hit;
            res_full_ff    <= !hit && (32'(stored_ff) >= MAX_TEMPLATES);
            res_tid_ff     <= (!hit && (32'(stored_ff) >= MAX_TEMPLATES)) ? 8'd0
                                                                            : tid32[7:0];
            res_shift_ff   <= (hit && pano_ff) ? sh32[6:0] : 7'd0;
         end
         ST_COPY: begin
            cp_i_ff <= cp_i_ff + 1'b1;
         end
         default: ;
      endcase
      if (state_ff == ST_COPY)
         cp_addr_ff <= cpaddr32[SAW-1:0];
      if (p1_ff)
         sad_ff <= sad_ff + {{NW{1'b0}}, adiff};
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_matched_ff <= res_matched_ff;
         rsp_tid_ff     <= res_tid_ff;
         rsp_err_ff     <= res_err_ff;
         rsp_nc_ff      <= !found_ff;
         rsp_shift_ff   <= res_shift_ff;
         rsp_full_ff    <= res_full_ff;
      end
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (in_acc)
         view_mem[wr_idx] <= req_tdata;
      vb_rd_ff <= view_mem[vb_raddr];
   end

   always_ff @(posedge clock) begin
      if (cp_v_ff)
         store_mem[cp_addr_ff] <= vb_rd_ff;
      ts_rd_ff <= store_mem[ts_raddr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DECIDE) && !hit && (32'(stored_ff) < MAX_TEMPLATES))
         mean_mem[stored_ff[TW-1:0]] <= mean_ff;
      mean_rd_ff <= mean_mem[t_ff[TW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_full_ff, rsp_shift_ff, rsp_nc_ff, rsp_err_ff,
                        rsp_tid_ff, rsp_matched_ff};

   // A result is never both a match and a full-store report.
   a_match_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[33]))
      else $error("match and store_full reported together");

   // Without any candidate there can be no match.
   a_nc_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> !rsp_tdata[0])
      else $error("match reported without a candidate");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      32'(stored_ff) <= MAX_TEMPLATES)
      else $error("template count beyond store depth");

   // The cell count is cleared for the whole time a view is being processed.
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff == '0))
      else $error("cell count not cleared while busy");

endmodule
